@@ rtl/pcxrle_pkg.sv @@
// Shared types and constants of the PCX run-length scanline encoder.
package pcxrle_pkg;

    // Width of a run length and the marker that flags a count byte.
    localparam int COUNT_W = 6;
    localparam logic [7:0] RUN_MARK = 8'hC0;
    localparam logic [7:0] LITERAL_LIMIT = 8'd64;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_RUN = 63;
    localparam int DEF_QUEUE_DEPTH = 4;

    // One pixel request.
    typedef struct packed {
        logic [7:0] pixel;
        logic       line_end;
    } pix_item_t;

    // One encoded byte.
    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_of_item;
        logic       line_done;
    } code_item_t;

    // Work for the back end: up to two runs to emit, in order, for one pixel.
    typedef struct packed {
        logic               a_valid;
        logic [7:0]         a_value;
        logic [COUNT_W-1:0] a_count;
        logic               b_valid;
        logic [7:0]         b_value;
        logic [COUNT_W-1:0] b_count;
        logic               line_end;
    } run_cmd_t;

endpackage

@@ rtl/pcxrle_front.sv @@
// Front end: tracks the held run and turns each pixel into run commands.
module pcxrle_front #(
    parameter int MAX_RUN = pcxrle_pkg::DEF_MAX_RUN
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  pcxrle_pkg::pix_item_t pix_item,
    input  logic                  queue_full,
    output logic                  cmd_push,
    output pcxrle_pkg::run_cmd_t  cmd
);
    import pcxrle_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_RUN);

    logic [7:0]         held_value_reg, held_value_next;
    logic [COUNT_W-1:0] held_count_reg, held_count_next;
    logic               accept;
    logic               flush_before, flush_after;
    logic [COUNT_W-1:0] count_mid, count_grown;
    logic [7:0]         value_mid;

    // The queue sets the pace of the pixel channel.
    assign pix_stall = queue_full;
    assign accept = pix_valid && !pix_stall;

    // Close the held run when the value changes, then extend or start a run,
    // then close it again when it is full or the line ends.
    always_comb
    begin
        flush_before = (held_count_reg != '0)
                       && ((pix_item.pixel != held_value_reg) || (held_count_reg >= MAX_CNT));
        count_mid = flush_before ? '0 : held_count_reg;
        value_mid = (count_mid == '0) ? pix_item.pixel : held_value_reg;
        count_grown = (count_mid == '0) ? COUNT_W'(1) : count_mid + COUNT_W'(1);
        flush_after = (count_grown >= MAX_CNT) || pix_item.line_end;

        cmd.a_valid  = flush_before;
        cmd.a_value  = held_value_reg;
        cmd.a_count  = held_count_reg;
        cmd.b_valid  = flush_after;
        cmd.b_value  = value_mid;
        cmd.b_count  = count_grown;
        cmd.line_end = pix_item.line_end;

        cmd_push = accept && (flush_before || flush_after);

        held_value_next = held_value_reg;
        held_count_next = held_count_reg;
        if (accept)
        begin
            held_value_next = value_mid;
            held_count_next = flush_after ? '0 : count_grown;
        end
    end

    // Held run state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_value_reg <= '0;
            held_count_reg <= '0;
        end
        else
        begin
            held_value_reg <= held_value_next;
            held_count_reg <= held_count_next;
        end
    end

    // A full run is always closed in the step that filled it.
    assert property (@(posedge clk) disable iff (!rst_n) held_count_reg < MAX_CNT)
        else $error("held run reached the maximum length without being emitted");

    // Every pixel that ends a line hands a command to the back end.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && pix_item.line_end |-> cmd_push && cmd.b_valid)
        else $error("line end accepted without closing the held run");

    // After a line end no run is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && pix_item.line_end |=> held_count_reg == '0)
        else $error("run held across a scanline boundary");

endmodule

@@ rtl/pcxrle_queue.sv @@
// Short queue of run commands between the front end and the back end.
module pcxrle_queue #(
    parameter int DEPTH = pcxrle_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  pcxrle_pkg::run_cmd_t   wr_cmd,
    input  logic                   pop,
    output logic                   head_valid,
    output pcxrle_pkg::run_cmd_t   head_cmd
);
    import pcxrle_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    run_cmd_t           entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    // The fill level never exceeds the depth.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL_CNT)
        else $error("run queue overflow");

    // A request offered while full must not be written.
    assert property (@(posedge clk) disable iff (!rst_n)
        push && full |=> $stable(wr_ptr_reg))
        else $error("run queue written while full");

    // Both pointers agree with the fill level when the queue is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> wr_ptr_reg == rd_ptr_reg)
        else $error("run queue pointers disagree with empty level");

endmodule

@@ rtl/pcxrle_back.sv @@
// Back end: expands run commands into code bytes, one per cycle unless stalled.
module pcxrle_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  pcxrle_pkg::run_cmd_t   head_cmd,
    output logic                   pop,
    output logic                   code_valid,
    input  logic                   code_stall,
    output pcxrle_pkg::code_item_t code_item
);
    import pcxrle_pkg::*;

    logic [1:0]  pos_reg, pos_next;
    logic        out_valid_reg, out_valid_next;
    code_item_t  out_reg, out_next;
    logic [1:0]  len_a, len_b;
    logic [2:0]  len_total;
    logic        is_last;
    logic        in_run_a;
    logic [1:0]  sub_pos;
    logic        load;

    // Bytes a run takes: a count byte is needed for a repeat or a high value.
    function automatic logic [1:0] run_len(input logic v, input logic [7:0] value,
                                           input logic [COUNT_W-1:0] count);
        logic [1:0] len;
        if (!v)
        begin
            len = 2'd0;
        end
        else if ((count > COUNT_W'(1)) || (value >= LITERAL_LIMIT))
        begin
            len = 2'd2;
        end
        else
        begin
            len = 2'd1;
        end
        return len;
    endfunction

    // Pick the byte at the current position of the head command.
    always_comb
    begin
        len_a     = run_len(head_cmd.a_valid, head_cmd.a_value, head_cmd.a_count);
        len_b     = run_len(head_cmd.b_valid, head_cmd.b_value, head_cmd.b_count);
        len_total = {1'b0, len_a} + {1'b0, len_b};
        is_last   = ({1'b0, pos_reg} == (len_total - 3'd1));
        in_run_a  = (pos_reg < len_a);
        sub_pos   = in_run_a ? pos_reg : (pos_reg - len_a);

        out_next = out_reg;
        if (in_run_a)
        begin
            out_next.code_byte = ((len_a == 2'd2) && (sub_pos == 2'd0))
                ? (RUN_MARK | {2'b00, head_cmd.a_count}) : head_cmd.a_value;
        end
        else
        begin
            out_next.code_byte = ((len_b == 2'd2) && (sub_pos == 2'd0))
                ? (RUN_MARK | {2'b00, head_cmd.b_count}) : head_cmd.b_value;
        end
        out_next.last_of_item = is_last;
        out_next.line_done    = is_last && head_cmd.line_end;

        load = head_valid && (!out_valid_reg || !code_stall);
        pop  = load && is_last;

        pos_next = pos_reg;
        if (load)
        begin
            pos_next = is_last ? 2'd0 : pos_reg + 2'd1;
        end

        out_valid_next = out_valid_reg;
        if (!out_valid_reg || !code_stall)
        begin
            out_valid_next = head_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output byte register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= out_next;
        end
    end

    assign code_valid = out_valid_reg;
    assign code_item  = out_reg;

    // The end of a line is always the last byte of its pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && code_item.line_done |-> code_item.last_of_item)
        else $error("line_done on a byte that is not the last of its pixel");

    // The position never passes the byte count of the head command.
    assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> ({1'b0, pos_reg} < len_total))
        else $error("byte position beyond the head command");

    // A command is only retired on its final byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> load && is_last)
        else $error("run command retired early");

endmodule

@@ rtl/pcx_rle_scanline_encoder_unit.sv @@
// Top level of the PCX run-length scanline encoder.
//
// Pixels enter on the pix channel (pix_valid, pix_stall, pix_item), one per
// request, with line_end set on the last pixel of a scanline. Code bytes leave
// on the code channel (code_valid, code_stall, code_item), one byte per
// request; last_of_item marks the final byte caused by a pixel and line_done
// the final byte of a scanline. A pixel that only extends a run yields no byte.
// The first byte of a pixel passes through the run queue and then the output
// byte register. Throughput: one pixel per cycle on the input while pix_stall
// is low and one byte per cycle on the output while code_stall is low; a pixel
// causes zero to four bytes, so the sustained pixel rate follows the byte count.
// The one-byte output channel sets the sustained rate; the QUEUE_DEPTH-entry run
// queue only absorbs bursts.
// Reset empties the queue, drops the output byte and clears the held run.
// While code_stall is high the offered byte holds; the queue keeps taking
// pixels until it is full, and then pix_stall rises.
module pcx_rle_scanline_encoder_unit #(
    parameter int MAX_RUN     = pcxrle_pkg::DEF_MAX_RUN,
    parameter int QUEUE_DEPTH = pcxrle_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pix_valid,
    output logic                   pix_stall,
    input  pcxrle_pkg::pix_item_t  pix_item,
    output logic                   code_valid,
    input  logic                   code_stall,
    output pcxrle_pkg::code_item_t code_item
);
    import pcxrle_pkg::*;

    logic       queue_push;
    logic       queue_full;
    run_cmd_t   front_cmd;
    run_cmd_t   head_cmd;
    logic       head_valid;
    logic       head_pop;

    pcxrle_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix_item   (pix_item),
        .queue_full (queue_full),
        .cmd_push   (queue_push),
        .cmd        (front_cmd)
    );

    pcxrle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (queue_push),
        .full       (queue_full),
        .wr_cmd     (front_cmd),
        .pop        (head_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    pcxrle_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (head_pop),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code_item  (code_item)
    );

endmodule
